// File: design/ess_pkg.sv
// shared constants, codes and item types for the exchange sort store
package ess_pkg;

	localparam int MAX_ITEMS   = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
	localparam int IDX_W       = $clog2(MAX_ITEMS);

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SHOW   = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] item_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic               last_of_run;
		logic [1:0]         status;
	} out_item_t;

	// request to the value memory for one cycle
	typedef struct packed {
		logic                          we;
		logic [IDX_W-1:0]              waddr;
		logic signed [VALUE_WIDTH-1:0] wdata;
		logic                          re;
		logic [IDX_W-1:0]              raddr;
	} ram_req_t;

endpackage

// File: design/exchange_sort_store.sv
// Exchange sort store: a bounded list of signed values with in-place sort and show.
//
// An item is taken at a rising edge with start high and busy low. An insert
// appends item_value at the tail and gives no result, unless the list is
// full: then the value is dropped and one result with the full status
// appears. A show on an empty list gives one result with the empty status.
// Either single result is on the result port, with strobe high, in the cycle
// after the item is taken.
// A show on n values sorts the memory in place, then reads it out in order:
// for each position i below n-1 a load, a compare-swap pass over positions
// i+1 to n-1 (one memory read a cycle, the running minimum held in a register)
// and a write-back of the minimum to position i (a lone load when n is one);
// then a read of each position in turn and a drain state. Results come
// one per cycle, the last one marked by last_of_run.
// busy stays high from the cycle after a show is taken until the last result
// has been registered. The single-port read of the value memory sets the pace.
// The receiver cannot stall: each result is valid for exactly one cycle.
// Reset empties the list; memory contents are not cleared, the count alone
// marks which entries are live. The list persists across shows.
module exchange_sort_store (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ess_pkg::in_item_t  item,
	output logic               busy,
	output logic               strobe,
	output ess_pkg::out_item_t result
);
	import ess_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_LOAD  = 6'b000010,
		S_SCAN  = 6'b000100,
		S_WB    = 6'b001000,
		S_EMIT  = 6'b010000,
		S_DRAIN = 6'b100000
	} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              count_q;
	logic [IDX_W-1:0]              i_q;
	logic [IDX_W-1:0]              j_q;
	logic signed [VALUE_WIDTH-1:0] cur_q;
	logic                          emit_s1;
	logic                          last_s1;
	out_item_t                     result_q;
	logic                          strobe_q;

	ram_req_t                      req;
	logic signed [VALUE_WIDTH-1:0] rdata;
	logic                          swap;
	logic                          load_more;
	logic                          scan_more;
	logic                          wb_more;
	logic                          emit_last;

	ess_value_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	// swap compare and loop bounds of the sort and read-out
	always_comb begin
		swap      = (cur_q >= rdata);
		load_more = (CNT_W'(i_q) + CNT_W'(1)) < count_q;
		scan_more = (CNT_W'(j_q) + CNT_W'(1)) < count_q;
		wb_more   = (CNT_W'(i_q) + CNT_W'(2)) < count_q;
		emit_last = (CNT_W'(j_q) + CNT_W'(1)) == count_q;
	end

	// memory requests per state
	always_comb begin
		req = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (item.operation == OP_INSERT) begin
						if (count_q < CNT_W'(MAX_ITEMS)) begin
							req.we    = 1'b1;
							req.waddr = count_q[IDX_W-1:0];
							req.wdata = VALUE_WIDTH'(item.item_value);
						end
					end else if (count_q != '0) begin
						req.re    = 1'b1;
						req.raddr = '0;
					end
				end
			end
			S_LOAD: begin
				if (load_more) begin
					req.re    = 1'b1;
					req.raddr = i_q + IDX_W'(1);
				end
			end
			S_SCAN: begin
				if (swap) begin
					req.we    = 1'b1;
					req.waddr = j_q;
					req.wdata = cur_q;
				end
				if (scan_more) begin
					req.re    = 1'b1;
					req.raddr = j_q + IDX_W'(1);
				end
			end
			S_WB: begin
				req.we    = 1'b1;
				req.waddr = i_q;
				req.wdata = cur_q;
				if (wb_more) begin
					req.re    = 1'b1;
					req.raddr = i_q + IDX_W'(1);
				end
			end
			S_EMIT: begin
				req.re    = 1'b1;
				req.raddr = j_q;
			end
			S_DRAIN: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer, count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			i_q      <= '0;
			j_q      <= '0;
			cur_q    <= '0;
			emit_s1  <= 1'b0;
			last_s1  <= 1'b0;
			result_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			emit_s1  <= 1'b0;
			// read-out data arrives in the cycle after its read
			if (emit_s1) begin
				result_q.out_value   <= 32'(rdata);
				result_q.last_of_run <= last_s1;
				result_q.status      <= ST_OK;
				strobe_q             <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (item.operation == OP_INSERT) begin
							if (count_q < CNT_W'(MAX_ITEMS)) begin
								count_q <= count_q + CNT_W'(1);
							end else begin
								result_q <= '{out_value: '0, last_of_run: 1'b0,
								              status: ST_FULL};
								strobe_q <= 1'b1;
							end
						end else if (count_q == '0) begin
							result_q <= '{out_value: '0, last_of_run: 1'b0,
							              status: ST_EMPTY};
							strobe_q <= 1'b1;
						end else begin
							i_q     <= '0;
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					cur_q <= rdata;
					if (load_more) begin
						j_q     <= i_q + IDX_W'(1);
						state_q <= S_SCAN;
					end else begin
						j_q     <= '0;
						state_q <= S_EMIT;
					end
				end
				S_SCAN: begin
					if (swap) begin
						cur_q <= rdata;
					end
					if (scan_more) begin
						j_q <= j_q + IDX_W'(1);
					end else begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (wb_more) begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= S_LOAD;
					end else begin
						j_q     <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					emit_s1 <= 1'b1;
					last_s1 <= emit_last;
					if (emit_last) begin
						state_q <= S_DRAIN;
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	// the list never grows past its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("item count above capacity");

	// the scan position always lies past the position being settled
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (j_q > i_q))
		else $error("scan index not past settle index");

	// a show on an empty list answers with one empty status next cycle
	a_empty_show: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.operation == OP_SHOW && count_q == '0)
		|=> (strobe && result.status == ST_EMPTY && !busy))
		else $error("empty show not answered");

	// no result leaves while the sort is still rearranging the memory
	a_quiet_sort: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_WB) |-> !strobe_q)
		else $error("result during sort");

	// the last read-out item is followed by the drain and then idle
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |=> (state_q == S_IDLE && strobe_q && result_q.last_of_run))
		else $error("read-out did not end on the last item");

endmodule

// File: design/ess_value_ram.sv
// value store: one write port and one registered read port
module ess_value_ram (
	input  logic                                  clk,
	input  ess_pkg::ram_req_t                     req,
	output logic signed [ess_pkg::VALUE_WIDTH-1:0] rdata
);
	import ess_pkg::*;

	logic signed [VALUE_WIDTH-1:0] mem [MAX_ITEMS];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// read port, registered output
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule
